// File: rtl/core/nbt_pkg.sv
// Shared types and constants for the NAK bitmap tracker.
// No dependencies; imported by every module of the block but nbt_ram.
`timescale 1ns / 1ps
`default_nettype none
package nbt_pkg;

  localparam int WORD_BITS          = 64;
  localparam int WB_LOG             = 6;
  localparam int MAX_SECTION_BLOCKS = 4096;
  localparam int START_W            = 28;   // covers 8191*8191 + 8191*8191 + 4095
  localparam int SZ_W               = 13;
  localparam int QA_W               = START_W - WB_LOG + 1;
  localparam int CNT_W              = 13;
  localparam int WI_W               = 6;
  localparam int CFG_DW             = 17;

  typedef enum logic [1:0] {
    MODE_ARRIVAL = 2'd0,
    MODE_QUERY   = 2'd1,
    MODE_CHECK   = 2'd2,
    MODE_RESTART = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_BIG_SECTIONS   = 3'd0,
    CFG_SECSIZE_BIG    = 3'd1,
    CFG_SECSIZE_SMALL  = 3'd2,
    CFG_TOTAL_SECTIONS = 3'd3,
    CFG_TOTAL_BLOCKS   = 3'd4,
    CFG_BLOCK_SIZE     = 3'd5,
    CFG_TRACKING_OFF   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [12:0] big;
    logic [12:0] sb;
    logic [12:0] ss;
    logic [12:0] tsec;
    logic [16:0] tblk;
    logic [15:0] bsize;
    logic        toff;
  } cfg_t;

  // One classified request handed from the front to the back
  typedef struct packed {
    mode_e               mode;
    status_e             status;
    logic [11:0]         sec;
    logic [START_W-1:0]  start;
    logic [START_W-1:0]  seq;
    logic [SZ_W-1:0]     size;
    logic                toff;
    logic                sec_lt_max;
    logic                sec_in_range;
  } cmd_t;

  function automatic logic [6:0] popcount64(input logic [WORD_BITS-1:0] w);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      s = s + 7'(w[i]);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/block_nak_bitmap_tracker_top.sv
// NAK bitmap tracker top: config registers, front, request queue, back.
// Each request passes the front (capture, multiply, add, classify), then the back:
// an arrival reads and rewrites one bitmap word, a query emits one result per word,
// a done check skips sections already marked done and scans the rest word by word,
// and a restart reruns the clearing pass. The front takes no new item until the last is queued.
// Reset: synchronous; a clearing pass over both bitmap RAMs
// runs after reset, with in_ready low until it ends.
`timescale 1ns / 1ps
`default_nettype none
module block_nak_bitmap_tracker_top import nbt_pkg::*; #(
  parameter int MAX_BLOCKS   = 65536,
  parameter int MAX_SECTIONS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [11:0]       in_section,
  input  wire logic [11:0]       in_sec_block,
  input  wire logic [15:0]       in_data_len,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [15:0]            out_seq_number,
  output logic [63:0]            out_nak_word,
  output logic [5:0]             out_word_index,
  output logic [12:0]            out_nak_count,
  output logic                   out_file_complete,
  output logic                   out_last
);

  cfg_t cfg_r;
  logic push, full, pop, empty, init_done;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.big   <= 13'd0;
      cfg_r.sb    <= 13'd4096;
      cfg_r.ss    <= 13'd4096;
      cfg_r.tsec  <= 13'd0;
      cfg_r.tblk  <= 17'd0;
      cfg_r.bsize <= 16'd1024;
      cfg_r.toff  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIG_SECTIONS:   cfg_r.big   <= cfg_data[12:0];
        CFG_SECSIZE_BIG:    cfg_r.sb    <= cfg_data[12:0];
        CFG_SECSIZE_SMALL:  cfg_r.ss    <= cfg_data[12:0];
        CFG_TOTAL_SECTIONS: cfg_r.tsec  <= cfg_data[12:0];
        CFG_TOTAL_BLOCKS:   cfg_r.tblk  <= cfg_data[16:0];
        CFG_BLOCK_SIZE:     cfg_r.bsize <= cfg_data[15:0];
        CFG_TRACKING_OFF:   cfg_r.toff  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  nbt_front #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_SECTIONS(MAX_SECTIONS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .en(init_done),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_section(in_section), .in_sec_block(in_sec_block), .in_data_len(in_data_len),
    .push(push), .push_cmd(push_cmd), .full(full)
  );

  nbt_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .din(push_cmd), .full(full),
    .pop(pop), .dout(pop_cmd), .empty(empty)
  );

  nbt_back #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_SECTIONS(MAX_SECTIONS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .fifo_empty(empty), .fifo_dout(pop_cmd), .fifo_pop(pop), .init_done(init_done),
    .out_ready(out_ready), .out_valid(out_valid), .out_status(out_status),
    .out_seq_number(out_seq_number), .out_nak_word(out_nak_word),
    .out_word_index(out_word_index), .out_nak_count(out_nak_count),
    .out_file_complete(out_file_complete), .out_last(out_last)
  );

endmodule
`default_nettype wire

// File: rtl/core/nbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nbt_ram #(
  parameter int W = 64,
  parameter int D = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [W-1:0]       rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/nbt_fifo.sv
// Two-entry request queue between the front and the back.
// Depends on nbt_pkg for cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module nbt_fifo import nbt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/nbt_front.sv
// Front end: accepts input items, computes section geometry and classifies.
// Depends on nbt_pkg; feeds nbt_fifo.
`timescale 1ns / 1ps
`default_nettype none
module nbt_front import nbt_pkg::*; #(
  parameter int MAX_BLOCKS   = 65536,
  parameter int MAX_SECTIONS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        en,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [11:0] in_section,
  input  wire logic [11:0] in_sec_block,
  input  wire logic [15:0] in_data_len,
  output logic             push,
  output cmd_t             push_cmd,
  input  wire logic        full
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_CLS} fstate_t;

  fstate_t            state_r;
  logic [1:0]         mode_r;
  logic [11:0]        sec_r, blk_r;
  logic [15:0]        dlen_r;
  logic               lo_r;
  logic [25:0]        m1_r, m2_r;
  logic [START_W-1:0] start_r;

  logic [12:0]        sec13, fa, fb, raw;
  logic               lo;
  logic [START_W-1:0] seq, tot;
  logic               lt_max;
  status_e            st;

  assign sec13 = {1'b0, sec_r};
  assign lo    = sec13 < cfg.big;
  assign fa    = lo ? sec13 : cfg.big;
  assign fb    = lo ? 13'd0 : (sec13 - cfg.big);

  assign seq    = start_r + START_W'(blk_r);
  assign tot    = START_W'(cfg.tblk);
  assign raw    = lo_r ? cfg.sb : cfg.ss;
  assign lt_max = 32'(sec_r) < MAX_SECTIONS;

  always_comb begin
    if (cfg.toff) begin
      st = ST_DONE;
    end else if (seq >= tot || 32'(seq) >= MAX_BLOCKS) begin
      st = ST_RANGE;
    end else if (dlen_r != cfg.bsize &&
                 ((START_W + 1)'(seq) + 1'b1) != (START_W + 1)'(cfg.tblk)) begin
      st = ST_BAD_LEN;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    push_cmd.mode         = mode_e'(mode_r);
    push_cmd.status       = st;
    push_cmd.sec          = sec_r;
    push_cmd.start        = start_r;
    push_cmd.seq          = seq;
    push_cmd.size         = (32'(raw) > MAX_SECTION_BLOCKS) ? SZ_W'(MAX_SECTION_BLOCKS) : raw;
    push_cmd.toff         = cfg.toff;
    push_cmd.sec_lt_max   = lt_max;
    push_cmd.sec_in_range = lt_max && (sec13 < cfg.tsec);
  end

  assign in_ready = (state_r == F_IDLE) && en;
  assign push     = (state_r == F_CLS) && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            mode_r  <= in_mode;
            sec_r   <= in_section;
            blk_r   <= in_sec_block;
            dlen_r  <= in_data_len;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          m1_r    <= {13'd0, fa} * {13'd0, cfg.sb};
          m2_r    <= {13'd0, fb} * {13'd0, cfg.ss};
          lo_r    <= lo;
          state_r <= F_ADD;
        end
        F_ADD: begin
          start_r <= START_W'(m1_r) + START_W'(m2_r);
          state_r <= F_CLS;
        end
        F_CLS: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/nbt_back.sv
// Back end: owns the block and section bitmaps and executes requests.
// Depends on nbt_pkg and nbt_ram; pops requests from nbt_fifo.
`timescale 1ns / 1ps
`default_nettype none
module nbt_back import nbt_pkg::*; #(
  parameter int MAX_BLOCKS   = 65536,
  parameter int MAX_SECTIONS = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             fifo_empty,
  input  wire cmd_t             fifo_dout,
  output logic                  fifo_pop,
  output logic                  init_done,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [15:0]           out_seq_number,
  output logic [WORD_BITS-1:0]  out_nak_word,
  output logic [WI_W-1:0]       out_word_index,
  output logic [CNT_W-1:0]      out_nak_count,
  output logic                  out_file_complete,
  output logic                  out_last
);

  localparam int OB_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int OAW      = (OB_WORDS > 1) ? $clog2(OB_WORDS) : 1;
  localparam int SAW      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CLR_N    = (OB_WORDS > MAX_SECTIONS) ? OB_WORDS : MAX_SECTIONS;
  localparam int CW       = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  typedef enum logic [3:0] {
    B_INIT, B_IDLE, B_ARD, B_AWR, B_QDRD, B_QDCK, B_WR0, B_WL0,
    B_WRN, B_WLN, B_WOUT, B_DRD, B_DCK, B_CLR, B_EMIT
  } bstate_t;

  bstate_t               state_r;
  cmd_t                  c_r;
  logic [QA_W-1:0]       qa_r;
  logic                  rv_r;
  logic [WORD_BITS-1:0]  prev_r, word_r;
  logic [WB_LOG-1:0]     off_r;
  logic [SZ_W-1:0]       szrem_r;
  logic signed [START_W:0] lrem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [WI_W-1:0]       wi_r;
  logic                  chk_r;
  logic [13:0]           sc_r;
  logic [START_W-1:0]    st_r;
  logic [CW-1:0]         clr_r;
  status_e               p_status_r;
  logic [15:0]           p_seq_r;
  logic                  p_fc_r;

  logic                  ob_we;
  logic [OAW-1:0]        ob_waddr, ob_raddr;
  logic [WORD_BITS-1:0]  ob_wdata, ob_rdata;
  logic                  dn_we;
  logic [SAW-1:0]        dn_waddr, dn_raddr;
  logic [0:0]            dn_wdata, dn_rdata;

  logic                  ospace, wlast, clr_end;
  logic [START_W-1:0]    lim;
  logic [13:0]           ns;
  logic [12:0]           raw_sc, size_sc;
  logic [6:0]            pop;
  logic [WORD_BITS-1:0]  rdcur, mask, word_nxt;
  logic [2*WORD_BITS-1:0] sh;
  logic signed [START_W:0] mn;
  logic [6:0]            vc;

  nbt_ram #(.W(WORD_BITS), .D(OB_WORDS)) u_ob_ram (
    .clk(clk), .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
    .raddr(ob_raddr), .rdata(ob_rdata)
  );

  nbt_ram #(.W(1), .D(MAX_SECTIONS)) u_done_ram (
    .clk(clk), .we(dn_we), .waddr(dn_waddr), .wdata(dn_wdata),
    .raddr(dn_raddr), .rdata(dn_rdata)
  );

  assign ospace    = !out_valid || out_ready;
  assign wlast     = szrem_r <= SZ_W'(WORD_BITS);
  assign clr_end   = (32'(clr_r) == CLR_N - 1);
  assign init_done = (state_r != B_INIT);
  assign fifo_pop  = (state_r == B_IDLE) && !fifo_empty;

  assign lim     = (32'(cfg.tblk) < MAX_BLOCKS) ? START_W'(cfg.tblk) : START_W'(MAX_BLOCKS);
  assign ns      = (32'(cfg.tsec) > MAX_SECTIONS) ? 14'(MAX_SECTIONS) : {1'b0, cfg.tsec};
  assign raw_sc  = (sc_r < {1'b0, cfg.big}) ? cfg.sb : cfg.ss;
  assign size_sc = (32'(raw_sc) > MAX_SECTION_BLOCKS) ? SZ_W'(MAX_SECTION_BLOCKS) : raw_sc;
  assign pop     = popcount64(word_r);

  // Valid bits in the current word: bounded by the section and by the file end
  assign mn = ($signed({{(START_W + 1 - SZ_W){1'b0}}, szrem_r}) < lrem_r) ?
              $signed({{(START_W + 1 - SZ_W){1'b0}}, szrem_r}) : lrem_r;
  always_comb begin
    if (mn <= 0) begin
      vc = 7'd0;
    end else if (mn >= WORD_BITS) begin
      vc = 7'(WORD_BITS);
    end else begin
      vc = 7'(mn);
    end
  end
  assign mask     = (vc == 7'(WORD_BITS)) ? '1 :
                    ((WORD_BITS'(1) << vc[WB_LOG-1:0]) - WORD_BITS'(1));
  assign rdcur    = rv_r ? ob_rdata : '0;
  assign sh       = {rdcur, prev_r} >> off_r;
  assign word_nxt = sh[WORD_BITS-1:0] & mask;

  always_comb begin
    ob_raddr = qa_r[OAW-1:0];
    if (state_r == B_ARD || state_r == B_AWR) begin
      ob_raddr = c_r.seq[WB_LOG +: OAW];
    end
    ob_we    = 1'b0;
    ob_waddr = clr_r[OAW-1:0];
    ob_wdata = '1;
    dn_we    = 1'b0;
    dn_waddr = SAW'(clr_r);
    dn_wdata = 1'b0;
    dn_raddr = (state_r == B_QDRD) ? SAW'(c_r.sec) : SAW'(sc_r);
    case (state_r)
      B_INIT, B_CLR: begin
        ob_we = 32'(clr_r) < OB_WORDS;
        dn_we = 32'(clr_r) < MAX_SECTIONS;
      end
      B_AWR: begin
        ob_we    = 1'b1;
        ob_waddr = c_r.seq[WB_LOG +: OAW];
        ob_wdata = ob_rdata & ~(WORD_BITS'(1) << c_r.seq[WB_LOG-1:0]);
      end
      B_WOUT: begin
        dn_wdata = 1'b1;
        dn_waddr = chk_r ? SAW'(sc_r) : SAW'(c_r.sec);
        if (chk_r) begin
          dn_we = wlast && (word_r == '0);
        end else begin
          dn_we = ospace && wlast && (cnt_r == '0) && (pop == 7'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_INIT;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        B_INIT, B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_end) begin
            clr_r <= '0;
            if (state_r == B_INIT) begin
              state_r <= B_IDLE;
            end else begin
              p_status_r <= ST_OK;
              p_seq_r    <= '0;
              p_fc_r     <= 1'b0;
              state_r    <= B_EMIT;
            end
          end
        end
        B_IDLE: begin
          if (!fifo_empty) begin
            c_r        <= fifo_dout;
            p_status_r <= ST_OK;
            p_seq_r    <= '0;
            p_fc_r     <= 1'b0;
            case (fifo_dout.mode)
              MODE_ARRIVAL: begin
                p_seq_r    <= fifo_dout.seq[15:0];
                p_status_r <= fifo_dout.status;
                state_r    <= (fifo_dout.status == ST_OK) ? B_ARD : B_EMIT;
              end
              MODE_QUERY: begin
                if (fifo_dout.toff) begin
                  p_status_r <= ST_DONE;
                  state_r    <= B_EMIT;
                end else if (fifo_dout.sec_lt_max) begin
                  state_r <= B_QDRD;
                end else begin
                  p_status_r <= ST_RANGE;
                  state_r    <= B_EMIT;
                end
              end
              MODE_CHECK: begin
                if (fifo_dout.toff) begin
                  p_status_r <= ST_DONE;
                  p_fc_r     <= 1'b1;
                  state_r    <= B_EMIT;
                end else begin
                  sc_r    <= '0;
                  st_r    <= '0;
                  state_r <= B_DRD;
                end
              end
              MODE_RESTART: state_r <= B_CLR;
              default: state_r <= B_IDLE;
            endcase
          end
        end
        B_ARD: state_r <= B_AWR;
        B_AWR: state_r <= B_EMIT;
        B_QDRD: state_r <= B_QDCK;
        B_QDCK: begin
          if (dn_rdata[0]) begin
            p_status_r <= ST_DONE;
            state_r    <= B_EMIT;
          end else if (!c_r.sec_in_range) begin
            p_status_r <= ST_RANGE;
            state_r    <= B_EMIT;
          end else begin
            qa_r    <= QA_W'(c_r.start >> WB_LOG);
            off_r   <= c_r.start[WB_LOG-1:0];
            szrem_r <= c_r.size;
            lrem_r  <= $signed({1'b0, lim}) - $signed({1'b0, c_r.start});
            cnt_r   <= '0;
            wi_r    <= '0;
            chk_r   <= 1'b0;
            state_r <= B_WR0;
          end
        end
        B_WR0: begin
          rv_r    <= 32'(qa_r) < OB_WORDS;
          state_r <= B_WL0;
        end
        B_WL0: begin
          prev_r  <= rdcur;
          qa_r    <= qa_r + 1'b1;
          state_r <= B_WRN;
        end
        B_WRN: begin
          rv_r    <= 32'(qa_r) < OB_WORDS;
          state_r <= B_WLN;
        end
        B_WLN: begin
          word_r  <= word_nxt;
          prev_r  <= rdcur;
          qa_r    <= qa_r + 1'b1;
          state_r <= B_WOUT;
        end
        B_WOUT: begin
          if (chk_r) begin
            if (word_r != '0) begin
              p_fc_r  <= 1'b0;
              state_r <= B_EMIT;
            end else if (wlast) begin
              sc_r    <= sc_r + 14'd1;
              st_r    <= st_r + START_W'(raw_sc);
              state_r <= B_DRD;
            end else begin
              szrem_r <= szrem_r - SZ_W'(WORD_BITS);
              lrem_r  <= lrem_r - $signed((START_W + 1)'(WORD_BITS));
              state_r <= B_WRN;
            end
          end else if (ospace) begin
            out_valid         <= 1'b1;
            out_status        <= ST_OK;
            out_seq_number    <= '0;
            out_nak_word      <= word_r;
            out_word_index    <= wi_r;
            out_nak_count     <= wlast ? (cnt_r + CNT_W'(pop)) : '0;
            out_file_complete <= 1'b0;
            out_last          <= wlast;
            cnt_r             <= cnt_r + CNT_W'(pop);
            wi_r              <= wi_r + 1'b1;
            szrem_r           <= szrem_r - SZ_W'(WORD_BITS);
            lrem_r            <= lrem_r - $signed((START_W + 1)'(WORD_BITS));
            state_r           <= wlast ? B_IDLE : B_WRN;
          end
        end
        B_DRD: begin
          if (sc_r >= ns) begin
            p_fc_r  <= 1'b1;
            state_r <= B_EMIT;
          end else begin
            state_r <= B_DCK;
          end
        end
        B_DCK: begin
          if (dn_rdata[0]) begin
            sc_r    <= sc_r + 14'd1;
            st_r    <= st_r + START_W'(raw_sc);
            state_r <= B_DRD;
          end else begin
            qa_r    <= QA_W'(st_r >> WB_LOG);
            off_r   <= st_r[WB_LOG-1:0];
            szrem_r <= size_sc;
            lrem_r  <= $signed({1'b0, lim}) - $signed({1'b0, st_r});
            chk_r   <= 1'b1;
            state_r <= B_WR0;
          end
        end
        B_EMIT: begin
          if (ospace) begin
            out_valid         <= 1'b1;
            out_status        <= p_status_r;
            out_seq_number    <= p_seq_r;
            out_nak_word      <= '0;
            out_word_index    <= '0;
            out_nak_count     <= '0;
            out_file_complete <= p_fc_r;
            out_last          <= 1'b1;
            state_r           <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_INIT) |-> !fifo_pop)
    else $error("request popped during clearing pass");

  a_arrival_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_AWR) |-> ((ob_wdata & ~ob_rdata) == '0))
    else $error("arrival write set a block bit");

  a_done_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    dn_we |-> (state_r == B_WOUT || state_r == B_INIT || state_r == B_CLR))
    else $error("section done bit written from an unexpected state");

  a_word_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WOUT && wlast && chk_r == 1'b0) |-> (32'(pop) <= 32'(szrem_r)))
    else $error("last NAK word has bits beyond the section");
`endif

endmodule
`default_nettype wire

// File: dv/block_nak_bitmap_tracker_top_test.sv
// Self-checking testbench for block_nak_bitmap_tracker_top: a scoreboard class
// predicts every result from its own bitmap copy; tasks drive config and requests.
// Depends on nbt_pkg and the tracker RTL only.
`timescale 1ns / 1ps
module block_nak_bitmap_tracker_top_test;
  import nbt_pkg::*;

  localparam int NBLK  = 65536;
  localparam int NSEC  = 4096;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] seq;
    logic [63:0] nak;
    logic [5:0]  wi;
    logic [12:0] cnt;
    logic        fc;
    logic        last;
  } nak_result_t;

  class nak_tracker_sb;
    bit [12:0] big, sb, ss, tsec;
    bit [16:0] tblk;
    bit [15:0] bsize;
    bit        toff;
    bit        outstanding[NBLK];
    bit        sec_done[NSEC];
    nak_result_t pending_q[$];
    int errors;

    function void clear_bitmaps();
      foreach (outstanding[i]) outstanding[i] = 1'b1;
      foreach (sec_done[i]) sec_done[i] = 1'b0;
    endfunction

    function void reset_state();
      big = 0; sb = 4096; ss = 4096; tsec = 0; tblk = 0; bsize = 1024; toff = 0;
      clear_bitmaps();
      pending_q.delete();
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [16:0] val);
      case (idx)
        CFG_BIG_SECTIONS:   big = val[12:0];
        CFG_SECSIZE_BIG:    sb = val[12:0];
        CFG_SECSIZE_SMALL:  ss = val[12:0];
        CFG_TOTAL_SECTIONS: tsec = val[12:0];
        CFG_TOTAL_BLOCKS:   tblk = val;
        CFG_BLOCK_SIZE:     bsize = val[15:0];
        CFG_TRACKING_OFF:   toff = val[0];
        default: ;
      endcase
    endfunction

    function void geometry(longint sec, output longint first, output longint size);
      if (sec >= big) begin
        first = longint'(big) * sb + (sec - big) * longint'(ss);
        size = ss;
      end else begin
        first = sec * longint'(sb);
        size = sb;
      end
      if (size > MAX_SECTION_BLOCKS) size = MAX_SECTION_BLOCKS;
    endfunction

    function bit is_missing(longint idx);
      if (idx >= tblk || idx >= NBLK) return 1'b0;
      return outstanding[idx];
    endfunction

    function void push(logic [1:0] st, longint seq, logic [63:0] nak, int wi,
                       int cnt, bit fc, bit last);
      nak_result_t r;
      r.status = st; r.seq = seq[15:0]; r.nak = nak; r.wi = wi[5:0];
      r.cnt = cnt[12:0]; r.fc = fc; r.last = last;
      pending_q.push_back(r);
    endfunction

    // Predict all results of one accepted request and advance the state.
    function void note_request(mode_e m, logic [11:0] sec, logic [11:0] blk,
                               logic [15:0] dlen);
      longint first, size, seq, words, cnt;
      logic [63:0] w;
      case (m)
        MODE_ARRIVAL: begin
          geometry(sec, first, size);
          seq = first + blk;
          if (toff) push(ST_DONE, seq, 0, 0, 0, 0, 1);
          else if (seq >= tblk || seq >= NBLK) push(ST_RANGE, seq, 0, 0, 0, 0, 1);
          else if (dlen != bsize && seq != longint'(tblk) - 1)
            push(ST_BAD_LEN, seq, 0, 0, 0, 0, 1);
          else begin
            outstanding[seq] = 1'b0;
            push(ST_OK, seq, 0, 0, 0, 0, 1);
          end
        end
        MODE_QUERY: begin
          if (toff || sec_done[sec]) push(ST_DONE, 0, 0, 0, 0, 0, 1);
          else if (sec >= tsec) push(ST_RANGE, 0, 0, 0, 0, 0, 1);
          else begin
            geometry(sec, first, size);
            cnt = 0;
            for (longint j = 0; j < size; j++) cnt += is_missing(first + j);
            words = (size + WORD_BITS - 1) / WORD_BITS;
            if (words == 0) words = 1;
            if (words > 64) words = 64;
            for (int k = 0; k < words; k++) begin
              w = '0;
              for (int j = 0; j < WORD_BITS; j++)
                if (k * WORD_BITS + j < size && is_missing(first + k * WORD_BITS + j))
                  w[j] = 1'b1;
              push(ST_OK, 0, w, k, (k + 1 == words) ? cnt : 0, 0, k + 1 == words);
            end
            if (cnt == 0) sec_done[sec] = 1'b1;
          end
        end
        MODE_CHECK: begin
          if (toff) push(ST_DONE, 0, 0, 0, 0, 1, 1);
          else begin
            for (int s = 0; s < tsec && s < NSEC; s++) begin
              if (sec_done[s]) continue;
              geometry(s, first, size);
              for (longint j = 0; j < size; j++)
                if (is_missing(first + j)) begin
                  push(ST_OK, 0, 0, 0, 0, 0, 1);
                  return;
                end
              sec_done[s] = 1'b1;
            end
            push(ST_OK, 0, 0, 0, 0, 1, 1);
          end
        end
        default: begin
          clear_bitmaps();
          push(ST_OK, 0, 0, 0, 0, 0, 1);
        end
      endcase
    endfunction

    function void check_result(nak_result_t got);
      nak_result_t exp;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d seq %0d nak %h",
                                   got.status, got.seq, got.nak);
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp st%0d seq%0d nak%h wi%0d cnt%0d fc%0d last%0d",
                   exp.status, exp.seq, exp.nak, exp.wi, exp.cnt, exp.fc, exp.last);
          $display("          got st%0d seq%0d nak%h wi%0d cnt%0d fc%0d last%0d",
                   got.status, got.seq, got.nak, got.wi, got.cnt, got.fc, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [11:0] in_section = '0;
  logic [11:0] in_sec_block = '0;
  logic [15:0] in_data_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_seq_number;
  logic [63:0] out_nak_word;
  logic [5:0]  out_word_index;
  logic [12:0] out_nak_count;
  logic        out_file_complete;
  logic        out_last;

  nak_tracker_sb tracker = new();
  int idle_pct = 6;
  int holdoff_reqs = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int cycles = 0;

  block_nak_bitmap_tracker_top i_dut (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (holdoff_seen != holdoff_reqs) begin
      holdoff_seen = holdoff_reqs;
      holdoff_left = 400;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    nak_result_t r;
    if (rst_n && out_valid && out_ready) begin
      r.status = out_status; r.seq = out_seq_number; r.nak = out_nak_word;
      r.wi = out_word_index; r.cnt = out_nak_count; r.fc = out_file_complete;
      r.last = out_last;
      tracker.check_result(r);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain outstanding results, then give the block time to settle.
  task automatic wait_idle();
    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic setup(int big, int sb, int ss, int tsec, int tblk, int bsize, bit toff);
    wait_idle();
    write_reg(CFG_BIG_SECTIONS, big);
    write_reg(CFG_SECSIZE_BIG, sb);
    write_reg(CFG_SECSIZE_SMALL, ss);
    write_reg(CFG_TOTAL_SECTIONS, tsec);
    write_reg(CFG_TOTAL_BLOCKS, tblk);
    write_reg(CFG_BLOCK_SIZE, bsize);
    write_reg(CFG_TRACKING_OFF, toff);
  endtask

  task automatic send(mode_e m, int sec, int blk, int dlen);
    in_valid <= 1'b1;
    in_mode <= m;
    in_section <= sec[11:0];
    in_sec_block <= blk[11:0];
    in_data_len <= dlen[15:0];
    do @(posedge clk); while (!in_ready);
    tracker.note_request(m, sec[11:0], blk[11:0], dlen[15:0]);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Mostly well-formed requests against the live geometry; the rest is noise.
  task automatic random_requests(int n);
    longint first, size;
    int sec, pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send(mode_e'($urandom_range(0, 2)), $urandom_range(0, 4095),
             $urandom_range(0, 4095), $urandom_range(0, 65535));
      end else begin
        sec = (tracker.tsec > 0) ? $urandom_range(0, tracker.tsec - 1) : 0;
        tracker.geometry(sec, first, size);
        if (pick < 70)
          send(MODE_ARRIVAL, sec, $urandom_range(0, size - 1),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : tracker.bsize);
        else if (pick < 88) send(MODE_QUERY, sec, 0, 0);
        else if (pick < 98) send(MODE_CHECK, 0, 0, 0);
        else send(MODE_RESTART, $urandom_range(0, 4095), 0, 0);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    tracker.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two large sections of 70 blocks, three small ones of 5; 155 blocks.
    setup(2, 70, 5, 5, 155, 16, 0);
    send(MODE_ARRIVAL, 0, 0, 16);
    send(MODE_ARRIVAL, 0, 1, 15);
    send(MODE_ARRIVAL, 0, 2, 65535);
    send(MODE_ARRIVAL, 4095, 4095, 16);
    send(MODE_ARRIVAL, 1, 69, 16);
    send(MODE_QUERY, 0, 0, 0);
    send(MODE_QUERY, 1, 0, 0);
    send(MODE_QUERY, 5, 0, 0);
    send(MODE_QUERY, 4095, 0, 0);
    send(MODE_CHECK, 0, 0, 0);
    // Fill the last section; its final block may be short.
    for (int b = 0; b < 4; b++) send(MODE_ARRIVAL, 4, b, 16);
    send(MODE_ARRIVAL, 4, 4, 0);
    send(MODE_QUERY, 4, 0, 0);
    send(MODE_QUERY, 4, 0, 0);
    send(MODE_CHECK, 0, 0, 0);
    send(MODE_RESTART, 0, 0, 0);
    send(MODE_QUERY, 4, 0, 0);
    in_valid <= 1'b0;
    holdoff_reqs++;
    random_requests(40);

    // Largest counts and sizes at their limits, one-block small sections.
    setup(4096, 16, 1, 4096, 65536, 65535, 0);
    send(MODE_ARRIVAL, 4095, 15, 65535);
    send(MODE_ARRIVAL, 4095, 4095, 65535);
    random_requests(25);

    // Full-width sections with no idling.
    idle_pct = 0;
    setup(0, 1, 4096, 3, 10000, 1, 0);
    send(MODE_QUERY, 2, 0, 0);
    random_requests(35);
    idle_pct = 6;

    setup(0, 4096, 4096, 0, 0, 1, 1);
    random_requests(15);

    setup(3, 1, 64, 4, 67, 1024, 0);
    random_requests(15);

    wait_idle();
    if (tracker.errors == 0 && tracker.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/nbt_pkg.sv
rtl/core/nbt_ram.sv
rtl/core/nbt_fifo.sv
rtl/core/nbt_front.sv
rtl/core/nbt_back.sv
rtl/core/block_nak_bitmap_tracker_top.sv
dv/block_nak_bitmap_tracker_top_test.sv
